@@ rtl/core/pfsc_pkg.sv @@
// Shared types and constants of the pattern-free substring counter.
package pfsc_pkg;

  localparam int SYM_W   = 5;
  localparam int CLEAN_W = 21;
  localparam int TOTAL_W = 40;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_PATTERN = 2'd1,
    ACT_BUILD   = 2'd2,
    ACT_TEXT    = 2'd3
  } act_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_P_ADDR,
    S_P_RD,
    S_P_EXE,
    S_P_FIN,
    S_B_START,
    S_B_NODE,
    S_B_F,
    S_B_RD,
    S_B_EX,
    S_B_NEXT,
    S_B_Q,
    S_T_ADDR,
    S_T_RD,
    S_T_GO,
    S_T_CH,
    S_T_CE,
    S_T_OUT
  } st_t;

endpackage

@@ rtl/core/pattern_free_substring_counter.sv @@
// Top level: trie build, failure-link pass and text matcher under one sequencer.
//
//  channel | signals                                         | handshake
//  --------+-------------------------------------------------+------------------------
//  command | action, symbol, last                            | start & !busy accepts
//  result  | clean_ending_here, running_total, text_done,    | done, one cycle, no stall
//          | dictionary_overflowed                           |
//
// Clear: the root child row is wiped. Pattern symbol: address, read, execute and finish states.
// Build: per trie node, a node state and a fail state, then a read and an execute state per symbol.
// Text symbol: goto lookup, then a check per failure chain entry, plus a build when links are stale.
// Reset passes through an init state that wipes the root row; busy is high meanwhile.
// The result register is written once per text symbol; the receiver cannot stall.
module pattern_free_substring_counter #(
  parameter int MAX_NODES     = 1024,
  parameter int ALPHABET_SIZE = 26,
  parameter int MAX_TEXT_LEN  = 1048576
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action,
  input  logic [pfsc_pkg::SYM_W-1:0]  symbol,
  input  logic                        last,
  output logic                        done,
  output logic [pfsc_pkg::CLEAN_W-1:0] clean_ending_here,
  output logic [pfsc_pkg::TOTAL_W-1:0] running_total,
  output logic                        text_done,
  output logic                        dictionary_overflowed
);

  import pfsc_pkg::*;

  localparam int NW     = $clog2(MAX_NODES);
  localparam int DW     = $clog2(MAX_NODES + 1);
  localparam int CW     = $clog2(ALPHABET_SIZE);
  localparam int GDEPTH = MAX_NODES * ALPHABET_SIZE;
  localparam int GW     = $clog2(GDEPTH);
  localparam int PW     = $clog2(MAX_TEXT_LEN + 1);
  localparam int VW     = ((PW > DW) ? PW : DW) + 1;

  // memories
  logic [NW-1:0]            goto_mem  [GDEPTH];
  logic [ALPHABET_SIZE-1:0] child_mem [MAX_NODES];
  logic [NW-1:0]            fail_mem  [MAX_NODES];
  logic [DW-1:0]            term_mem  [MAX_NODES];
  logic [NW-1:0]            queue_mem [MAX_NODES];

  // control registers
  st_t state, state_next;
  act_t action_q;
  logic [SYM_W-1:0] sym_q;
  logic last_q;
  logic [DW-1:0] nodes_used;
  logic [NW-1:0] cursor;
  logic [DW-1:0] depth;
  logic links_built;
  logic spoiled;
  logic overflow;
  logic alloc;
  logic [NW-1:0] new_node;
  logic [NW-1:0] match_state;
  logic [VW-1:0] blocked;
  logic [PW-1:0] text_position;
  logic [TOTAL_W-1:0] clean_total;
  logic [GW-1:0] slot, pbase, fbase;
  logic [NW-1:0] p, node;
  logic rootpass;
  logic [CW-1:0] c;
  logic [DW-1:0] head, tail;
  logic [ALPHABET_SIZE-1:0] row;

  // memory read data
  logic [NW-1:0]            goto_rd0, goto_rd1, fail_rd, queue_rd;
  logic [ALPHABET_SIZE-1:0] child_rd;
  logic [DW-1:0]            term_rd;

  // memory controls
  logic goto_we, child_we, fail_we, term_we, queue_we;
  logic [GW-1:0] goto_wa, goto_ra0, goto_ra1;
  logic [NW-1:0] goto_wd, child_wa, child_ra, fail_wa, fail_wd, fail_ra;
  logic [NW-1:0] term_wa, term_ra, queue_wa, queue_wd, queue_ra;
  logic [ALPHABET_SIZE-1:0] child_wd;
  logic [DW-1:0] term_wd;

  always_ff @(posedge clk) begin
    if (goto_we) goto_mem[goto_wa] <= goto_wd;
    goto_rd0 <= goto_mem[goto_ra0];
    goto_rd1 <= goto_mem[goto_ra1];
  end

  always_ff @(posedge clk) begin
    if (child_we) child_mem[child_wa] <= child_wd;
    child_rd <= child_mem[child_ra];
  end

  always_ff @(posedge clk) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    fail_rd <= fail_mem[fail_ra];
  end

  always_ff @(posedge clk) begin
    if (term_we) term_mem[term_wa] <= term_wd;
    term_rd <= term_mem[term_ra];
  end

  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    queue_rd <= queue_mem[queue_ra];
  end

  // decoded conditions
  logic accept;
  logic sym_bad, p_has, p_room, p_new, p_go, fin_mark, c_last, q_room;
  logic [NW-1:0] via;
  logic [VW-1:0] pos, sub_x, sub_y, sub_res;
  logic [TOTAL_W:0] sum;

  assign accept   = start && !busy;
  assign sym_bad  = 32'(sym_q) >= ALPHABET_SIZE;
  assign p_has    = child_rd[CW'(sym_q)];
  assign p_room   = nodes_used < DW'(MAX_NODES);
  assign p_new    = !spoiled && !sym_bad && !p_has && p_room;
  assign p_go     = !spoiled && !sym_bad && (p_has || p_room);
  assign fin_mark = last_q && !spoiled && (cursor != '0);
  assign c_last   = c == CW'(ALPHABET_SIZE - 1);
  assign q_room   = tail < DW'(MAX_NODES);
  assign via      = rootpass ? '0 : goto_rd0;
  assign pos      = (text_position < PW'(MAX_TEXT_LEN)) ? VW'(text_position)
                                                         : VW'(MAX_TEXT_LEN - 1);

  // shared subtractor: candidate block start, then clean count
  always_comb begin
    if (state == S_T_CE) begin
      sub_x = pos + VW'(2);
      sub_y = VW'(term_rd);
    end else begin
      sub_x = pos + VW'(1);
      sub_y = blocked;
    end
  end

  pfsc_sub_unit #(.W(VW)) u_sub (.x(sub_x), .y(sub_y), .diff(sub_res));

  assign sum = {1'b0, clean_total} + (TOTAL_W+1)'(sub_res);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT:    state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (act_t'(action))
            ACT_CLEAR:   state_next = S_CLR;
            ACT_PATTERN: state_next = S_P_ADDR;
            ACT_BUILD:   state_next = S_B_START;
            ACT_TEXT:    state_next = links_built ? S_T_ADDR : S_B_START;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_CLR:     state_next = S_IDLE;
      S_P_ADDR:  state_next = S_P_RD;
      S_P_RD:    state_next = S_P_EXE;
      S_P_EXE:   state_next = S_P_FIN;
      S_P_FIN:   state_next = S_IDLE;
      S_B_START: state_next = S_B_NODE;
      S_B_NODE:  state_next = S_B_F;
      S_B_F:     state_next = S_B_RD;
      S_B_RD:    state_next = S_B_EX;
      S_B_EX:    state_next = c_last ? S_B_NEXT : S_B_RD;
      S_B_NEXT: begin
        if (head < tail) state_next = S_B_Q;
        else if (action_q == ACT_TEXT) state_next = S_T_ADDR;
        else state_next = S_IDLE;
      end
      S_B_Q:     state_next = S_B_NODE;
      S_T_ADDR:  state_next = S_T_RD;
      S_T_RD:    state_next = S_T_GO;
      S_T_GO:    state_next = S_T_CH;
      S_T_CH:    state_next = (node == '0) ? S_T_OUT : S_T_CE;
      S_T_CE:    state_next = S_T_CH;
      S_T_OUT:   state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs: handshake and memory ports
  always_comb begin
    busy     = state != S_IDLE;
    goto_we  = 1'b0;
    goto_wa  = slot;
    goto_wd  = NW'(nodes_used);
    goto_ra0 = slot;
    goto_ra1 = pbase + GW'(c);
    child_we = 1'b0;
    child_wa = cursor;
    child_wd = child_rd | (ALPHABET_SIZE'(1) << CW'(sym_q));
    child_ra = cursor;
    fail_we  = 1'b0;
    fail_wa  = goto_rd1;
    fail_wd  = via;
    fail_ra  = node;
    term_we  = 1'b0;
    term_wa  = NW'(nodes_used);
    term_wd  = '0;
    term_ra  = node;
    queue_we = 1'b0;
    queue_wa = NW'(tail);
    queue_wd = goto_rd1;
    queue_ra = NW'(head);
    case (state)
      S_INIT, S_CLR: begin
        child_we = 1'b1;
        child_wa = '0;
        child_wd = '0;
      end
      S_P_EXE: begin
        child_we = p_new;
        goto_we  = p_new;
        term_we  = p_new;
      end
      S_P_FIN: begin
        child_we = alloc;
        child_wa = new_node;
        child_wd = '0;
        term_we  = fin_mark;
        term_wa  = cursor;
        term_wd  = depth;
      end
      S_B_NODE: begin
        child_ra = p;
        fail_ra  = p;
      end
      S_B_RD: goto_ra0 = fbase + GW'(c);
      S_B_EX: begin
        if (row[c]) begin
          fail_we  = 1'b1;
          queue_we = q_room;
        end else begin
          goto_we = 1'b1;
          goto_wa = pbase + GW'(c);
          goto_wd = via;
        end
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      nodes_used    <= DW'(1);
      cursor        <= '0;
      depth         <= '0;
      links_built   <= 1'b0;
      spoiled       <= 1'b0;
      overflow      <= 1'b0;
      alloc         <= 1'b0;
      match_state   <= '0;
      blocked       <= '0;
      text_position <= '0;
      clean_total   <= '0;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            action_q <= act_t'(action);
            sym_q    <= symbol;
            last_q   <= last;
          end
        end
        S_CLR: begin
          nodes_used    <= DW'(1);
          cursor        <= '0;
          depth         <= '0;
          links_built   <= 1'b0;
          spoiled       <= 1'b0;
          overflow      <= 1'b0;
          match_state   <= '0;
          blocked       <= '0;
          text_position <= '0;
          clean_total   <= '0;
        end
        // pattern insertion
        S_P_ADDR: slot <= GW'(cursor) * GW'(ALPHABET_SIZE) + GW'(sym_q);
        S_P_EXE: begin
          links_built <= 1'b0;
          alloc       <= p_new;
          new_node    <= NW'(nodes_used);
          if (!spoiled && !sym_bad && !p_has && !p_room) overflow <= 1'b1;
          if (!spoiled && !p_go) spoiled <= 1'b1;
          if (p_go) begin
            depth  <= depth + DW'(1);
            cursor <= p_has ? goto_rd0 : NW'(nodes_used);
          end
          if (p_new) nodes_used <= nodes_used + DW'(1);
        end
        S_P_FIN: begin
          if (last_q) begin
            cursor  <= '0;
            depth   <= '0;
            spoiled <= 1'b0;
          end
        end
        // breadth-first link pass
        S_B_START: begin
          head     <= '0;
          tail     <= '0;
          p        <= '0;
          rootpass <= 1'b1;
        end
        S_B_NODE: pbase <= GW'(p) * GW'(ALPHABET_SIZE);
        S_B_F: begin
          fbase <= rootpass ? '0 : GW'(fail_rd) * GW'(ALPHABET_SIZE);
          row   <= child_rd;
          c     <= '0;
        end
        S_B_EX: begin
          if (row[c] && q_room) tail <= tail + DW'(1);
          c <= c + CW'(1);
        end
        S_B_NEXT: begin
          if (head < tail) head <= head + DW'(1);
          else links_built <= 1'b1;
        end
        S_B_Q: begin
          p        <= queue_rd;
          rootpass <= 1'b0;
        end
        // text matching
        S_T_ADDR: slot <= GW'(match_state) * GW'(ALPHABET_SIZE) + GW'(sym_q);
        S_T_GO: begin
          match_state <= sym_bad ? '0 : goto_rd0;
          node        <= sym_bad ? '0 : goto_rd0;
        end
        S_T_CE: begin
          if ((term_rd != '0) && (sub_res > blocked)) blocked <= sub_res;
          node <= fail_rd;
        end
        S_T_OUT: begin
          done                  <= 1'b1;
          clean_ending_here     <= CLEAN_W'(sub_res);
          running_total         <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
          text_done             <= last_q;
          dictionary_overflowed <= overflow;
          if (last_q) begin
            match_state   <= '0;
            blocked       <= '0;
            text_position <= '0;
            clean_total   <= '0;
          end else begin
            clean_total <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
            if (text_position < PW'(MAX_TEXT_LEN)) text_position <= text_position + PW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/pfsc_sub_unit.sv @@
// Shared saturating subtractor: x - y, floored at zero.
module pfsc_sub_unit #(
  parameter int W = 8
) (
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  output logic [W-1:0] diff
);

  // one compare and one subtract
  assign diff = (x > y) ? (x - y) : '0;

endmodule

@@ rtl/core/pfsc_checker.sv @@
// Port-level checker for the pattern-free substring counter, with its bind.
module pfsc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic [pfsc_pkg::CLEAN_W-1:0] clean_ending_here,
  input logic [pfsc_pkg::TOTAL_W-1:0] running_total
);

  import pfsc_pkg::*;

  // an accepted transaction always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("not busy after accept");

  // a result only closes work that was in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without work");

  // the total already includes this symbol's count
  a_total_covers: assert property (@(posedge clk) disable iff (rst)
    done |-> running_total >= TOTAL_W'(clean_ending_here))
    else $error("total below clean count");

endmodule

bind pattern_free_substring_counter pfsc_checker u_pfsc_checker (.*);
